// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, held off by arst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

// antecedent implies consequent at the same edge
`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== hw/rtl/bte_pkg.sv =====
// ---------------------------------------------------------------------------
// bte_pkg
// types, constants, lookup tables and segment functions of the estimator
// ---------------------------------------------------------------------------
package bte_pkg;

	localparam int HISTORY_DEPTH = 32;
	localparam int IDX_W         = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

	localparam int ADC_W    = 10;
	localparam int TIME_W   = 32;
	localparam int OFS_W    = 24;
	localparam int REM_W    = 12;
	localparam int RATE_W   = 31;
	localparam int S_DATA_W = 48;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 48;
	localparam int RAM_W    = ADC_W + TIME_W;

	localparam int MUL_W    = 32;
	localparam int PROD_W   = 64;
	localparam int DIV_BITS = 56;
	localparam int DIV_CW   = $clog2(DIV_BITS + 1);

	localparam logic [OFS_W-1:0] OFFSET_MAX = {OFS_W{1'b1}};

	// reciprocal multipliers for the constant divides by 25 and 100
	localparam logic [MUL_W-1:0] REC25     = 32'd2622;
	localparam int               REC25_SH  = 16;
	localparam logic [MUL_W-1:0] REC100    = 32'd335545;
	localparam int               REC100_SH = 25;

	localparam logic [ADC_W-1:0] ADC_EMPTY     = 10'd100;
	localparam logic [ADC_W-1:0] ADC_LOW       = 10'd400;
	localparam logic [ADC_W-1:0] ADC_FULL      = 10'd790;
	localparam logic [ADC_W-1:0] ADC_HIGH      = 10'd800;
	localparam logic [7:0]       DIS_TOP_MIN   = 8'd170;
	localparam logic [7:0]       CHG_LOW_MIN   = 8'd124;
	localparam logic [MUL_W-1:0] SLOPE_SCALE   = 32'd1000;

	typedef enum logic [1:0] {
		REG_TIME_FACTOR  = 2'd0,
		REG_HISTORY_SIZE = 2'd1,
		REG_MIN_INTERVAL = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PREP, ST_CHK,
		ST_RD, ST_SQ, ST_PRD, ST_ACC,
		ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6, ST_D7, ST_D8, ST_D9, ST_D10, ST_D11,
		ST_DIV, ST_DEC,
		ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] base;
		logic [4:0] dm;
		logic [4:0] x;
	} seg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam logic [ADC_W-1:0] DIS_ADC [17] = '{10'd800, 10'd775, 10'd750, 10'd725, 10'd700,
		10'd675, 10'd650, 10'd625, 10'd600, 10'd575, 10'd550, 10'd525, 10'd500, 10'd475,
		10'd450, 10'd425, 10'd400};
	localparam logic [7:0] DIS_MIN [17] = '{8'd170, 8'd161, 8'd152, 8'd145, 8'd130, 8'd116,
		8'd109, 8'd100, 8'd88, 8'd68, 8'd56, 8'd43, 8'd37, 8'd29, 8'd22, 8'd12, 8'd0};
	localparam logic [ADC_W-1:0] CHG_ADC [17] = '{10'd400, 10'd425, 10'd450, 10'd475, 10'd500,
		10'd525, 10'd550, 10'd575, 10'd600, 10'd625, 10'd650, 10'd675, 10'd700, 10'd725,
		10'd750, 10'd775, 10'd800};
	localparam logic [7:0] CHG_MIN [17] = '{8'd124, 8'd119, 8'd113, 8'd104, 8'd94, 8'd86,
		8'd77, 8'd69, 8'd61, 8'd52, 8'd44, 8'd37, 8'd29, 8'd22, 8'd15, 8'd7, 8'd0};

	// discharge segment: first breakpoint at or below the reading wins
	function automatic seg_t dis_seg(input logic [ADC_W-1:0] adc);
		seg_t s;
		s = '0;
		if (adc >= ADC_HIGH) begin
			s.base = DIS_TOP_MIN;
		end else if (adc > ADC_LOW) begin
			for (int i = 15; i >= 0; i--) begin
				if (adc >= DIS_ADC[i+1]) begin
					s.base = DIS_MIN[i+1];
					s.dm   = 5'(DIS_MIN[i] - DIS_MIN[i+1]);
					s.x    = 5'(adc - DIS_ADC[i+1]);
				end
			end
		end
		return s;
	endfunction

	// charge segment: first breakpoint above the reading wins
	function automatic seg_t chg_seg(input logic [ADC_W-1:0] adc);
		seg_t s;
		s = '0;
		if (adc <= ADC_LOW) begin
			s.base = CHG_LOW_MIN;
		end else if (adc < ADC_HIGH) begin
			for (int i = 15; i >= 0; i--) begin
				if (adc < CHG_ADC[i+1]) begin
					s.base = CHG_MIN[i+1];
					s.dm   = 5'(CHG_MIN[i] - CHG_MIN[i+1]);
					s.x    = 5'(CHG_ADC[i+1] - adc);
				end
			end
		end
		return s;
	endfunction

endpackage

// ===== hw/rtl/bte_ram.sv =====
// ---------------------------------------------------------------------------
// bte_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module bte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/bte_mul.sv =====
// ---------------------------------------------------------------------------
// bte_mul
// shared unsigned multiplier with registered product
// ---------------------------------------------------------------------------
module bte_mul (
	input  logic                      clk,
	input  logic                      en,
	input  logic [bte_pkg::MUL_W-1:0]  a,
	input  logic [bte_pkg::MUL_W-1:0]  b,
	output logic [bte_pkg::PROD_W-1:0] p
);

	import bte_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p <= PROD_W'(a) * PROD_W'(b);
		end
	end

endmodule

// ===== hw/rtl/bte_div.sv =====
// ---------------------------------------------------------------------------
// bte_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module bte_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bte_pkg::DIV_BITS-1:0] dividend,
	input  logic [bte_pkg::PROD_W-1:0]   divisor,
	output logic [bte_pkg::DIV_BITS-1:0] quotient,
	output bte_pkg::div_stat_t           stat
);

	import bte_pkg::*;

	logic [DIV_CW-1:0]   cnt_q;
	logic [PROD_W-1:0]   rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic                done_q;
	logic [PROD_W-1:0]   shifted;
	logic                fits;

	assign shifted = {rem_q[PROD_W-2:0], quo_q[DIV_BITS-1]};
	assign fits    = shifted >= divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CW'(DIV_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == DIV_CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? shifted - divisor : shifted;
			quo_q <= {quo_q[DIV_BITS-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;

endmodule

// ===== hw/rtl/battery_time_estimator_core.sv =====
// ---------------------------------------------------------------------------
// battery_time_estimator_core
// battery remaining-time and charge-rate estimator over a sample history
// ---------------------------------------------------------------------------
// One reading is taken at a time and gives one result. An invalid reading or
// an empty battery while discharging goes straight to the result, and a reading
// with fewer than three samples in the history runs only the table lookup and
// scaling on the shared multiplier. With n >= 3 samples the sequencer first
// walks the sample ram, reading, squaring, forming the product and accumulating
// for each entry on the single shared multiplier, then runs a bit-serial divide
// for the slope, and then the table lookup unless the trend runs the wrong way.
// A result that is not taken holds the sequencer at its last step, so output
// stalls delay the next reading. The next reading is taken as soon as the
// sequencer is idle.
module battery_time_estimator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bte_pkg::S_DATA_W-1:0]  s_tdata,  // adc_value[9:0], now_seconds[41:10]
	input  logic [bte_pkg::S_USER_W-1:0]  s_tuser,  // reading_valid[0], is_charging[1]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bte_pkg::M_DATA_W-1:0]  m_tdata,  // remain_minutes[11:0], rate_x100[42:12]
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	import bte_pkg::*;

	`include "assert_macros.svh"

	state_t state_q, state_d;

	logic [9:0]  tf_q;
	logic [5:0]  hs_q;
	logic [15:0] mi_q;

	logic             vld_q, chg_q;
	logic [ADC_W-1:0] adc_q;
	logic [TIME_W-1:0] now_q;

	logic [IDX_W-1:0] head_q, idx_q;
	logic [CNT_W-1:0] cnt_q, h_q, i_q;
	logic             last_chg_q;

	logic [TIME_W-1:0] t0_q;
	logic [OFS_W-1:0]  t_q;
	logic [ADC_W-1:0]  a_q;
	logic [31:0]       st_q;
	logic [15:0]       sa_q;
	logic [63:0]       stt_q, sta_q, acc_q, den_q, mag_q;
	logic              neg_q;

	seg_t       seg_q;
	logic [7:0] tab_q;

	logic [REM_W-1:0]  held_rem_q;
	logic [RATE_W-1:0] held_rate_q;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	// shared units
	logic              mul_en;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] mul_p;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [RAM_W-1:0]  ram_wdata, ram_rdata;
	logic              div_start;
	logic [DIV_BITS-1:0] div_dividend, div_quo;
	div_stat_t         div_stat;

	bte_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	bte_ram #(
		.WIDTH (RAM_W),
		.DEPTH (HISTORY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (den_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// ---------------- configuration port ----------------
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_q <= 10'd100;
			hs_q <= 6'd20;
			mi_q <= 16'd30;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TIME_FACTOR:  tf_q <= pwdata[9:0];
				REG_HISTORY_SIZE: hs_q <= pwdata[5:0];
				REG_MIN_INTERVAL: mi_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TIME_FACTOR:  prdata = 32'(tf_q);
			REG_HISTORY_SIZE: prdata = 32'(hs_q);
			REG_MIN_INTERVAL: prdata = 32'(mi_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- ring bookkeeping ----------------
	logic             flip;
	logic [CNT_W-1:0] h_eff, cnt0, cnt1;
	logic [IDX_W-1:0] head0, head1, last_idx;

	always_comb begin
		if (hs_q == '0) begin
			h_eff = CNT_W'(1);
		end else if (int'(hs_q) > HISTORY_DEPTH) begin
			h_eff = CNT_W'(HISTORY_DEPTH);
		end else begin
			h_eff = CNT_W'(hs_q);
		end
		flip     = chg_q != last_chg_q;
		head0    = flip ? '0 : head_q;
		cnt0     = flip ? '0 : cnt_q;
		head1    = (CNT_W'(head0) >= h_eff) ? '0 : head0;
		cnt1     = (cnt0 > h_eff) ? h_eff : cnt0;
		last_idx = (head1 == '0) ? IDX_W'(h_eff - CNT_W'(1)) : IDX_W'(head1 - 1'b1);
	end

	logic [TIME_W-1:0] rd_time;
	logic [ADC_W-1:0]  rd_lvl;
	logic [TIME_W:0]   gap;
	logic              store;
	logic [IDX_W-1:0]  nh, oldest;
	logic [CNT_W-1:0]  nc;
	logic [CNT_W:0]    osum;

	assign rd_time = ram_rdata[TIME_W-1:0];
	assign rd_lvl  = ram_rdata[RAM_W-1:TIME_W];

	always_comb begin
		// a time running backwards gives a negative gap and counts as too soon
		gap   = {1'b0, now_q} - {1'b0, rd_time};
		store = (cnt_q == '0) || !($signed(gap) < $signed({17'b0, mi_q}));
		if (store) begin
			nh = (CNT_W'(head_q) + CNT_W'(1) == h_q) ? '0 : IDX_W'(CNT_W'(head_q) + CNT_W'(1));
			nc = (cnt_q < h_q) ? cnt_q + CNT_W'(1) : cnt_q;
		end else begin
			nh = head_q;
			nc = cnt_q;
		end
		osum   = (CNT_W+1)'(nh) + (CNT_W+1)'(h_q) - (CNT_W+1)'(nc);
		oldest = (osum >= (CNT_W+1)'(h_q)) ? IDX_W'(osum - (CNT_W+1)'(h_q)) : IDX_W'(osum);
	end

	// offset of the sample from the oldest one, clamped
	logic [TIME_W-1:0] t0_sel;
	logic [TIME_W:0]   toff;
	logic [OFS_W-1:0]  t_cur;

	always_comb begin
		t0_sel = (i_q == '0) ? rd_time : t0_q;
		toff   = {1'b0, rd_time} - {1'b0, t0_sel};
		if (toff[TIME_W]) begin
			t_cur = '0;
		end else if (toff[TIME_W-1:0] > TIME_W'(OFFSET_MAX)) begin
			t_cur = OFFSET_MAX;
		end else begin
			t_cur = toff[OFS_W-1:0];
		end
	end

	// slope decision and rate
	logic              s_zero, s_pos, s_neg;
	logic [31:0]       smag;
	logic [34:0]       prod6;
	logic [RATE_W-1:0] rate6;

	always_comb begin
		s_zero = (den_q == '0) || (div_quo == '0);
		s_pos  = !s_zero && !neg_q;
		s_neg  = !s_zero && neg_q;
		if (chg_q) begin
			smag = (div_quo > DIV_BITS'(32'h7fff_ffff)) ? 32'h7fff_ffff : div_quo[31:0];
		end else begin
			smag = (div_quo > DIV_BITS'(32'h8000_0000)) ? 32'h8000_0000 : div_quo[31:0];
		end
		prod6 = {1'b0, smag, 2'b00} + {2'b00, smag, 1'b0};
		rate6 = (prod6 > 35'h7fff_ffff) ? {RATE_W{1'b1}} : prod6[RATE_W-1:0];
	end

	logic [REM_W-1:0] scaled;
	assign scaled = mul_p[REC100_SH +: REM_W];

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_PREP;
			ST_PREP: begin
				if (!vld_q || (!chg_q && adc_q < ADC_EMPTY)) state_d = ST_OUT;
				else state_d = ST_CHK;
			end
			ST_CHK:  state_d = (nc >= CNT_W'(3)) ? ST_RD : ST_T1;
			ST_RD:   state_d = ST_SQ;
			ST_SQ:   state_d = ST_PRD;
			ST_PRD:  state_d = ST_ACC;
			ST_ACC:  state_d = (i_q + CNT_W'(1) == cnt_q) ? ST_D1 : ST_RD;
			ST_D1:   state_d = ST_D2;
			ST_D2:   state_d = ST_D3;
			ST_D3:   state_d = ST_D4;
			ST_D4:   state_d = ST_D5;
			ST_D5:   state_d = ST_D6;
			ST_D6:   state_d = ST_D7;
			ST_D7:   state_d = ST_D8;
			ST_D8:   state_d = ST_D9;
			ST_D9:   state_d = ST_D10;
			ST_D10:  state_d = ST_D11;
			ST_D11:  state_d = ST_DIV;
			ST_DIV:  if (div_stat.done) state_d = ST_DEC;
			ST_DEC:  state_d = (chg_q ? s_pos : s_neg) ? ST_T1 : ST_OUT;
			ST_T1:   state_d = ST_T2;
			ST_T2:   state_d = ST_T3;
			ST_T3:   state_d = ST_T4;
			ST_T4:   state_d = ST_T5;
			ST_T5:   state_d = ST_T6;
			ST_T6:   state_d = ST_T7;
			ST_T7:   state_d = ST_OUT;
			ST_OUT:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- sequencer: unit controls ----------------
	always_comb begin
		s_tready     = 1'b0;
		mul_en       = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		ram_we       = 1'b0;
		ram_waddr    = head_q;
		ram_wdata    = {adc_q, now_q};
		ram_raddr    = idx_q;
		div_start    = 1'b0;
		div_dividend = DIV_BITS'(acc_q + {mul_p[31:0], 32'b0});
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_PREP: ram_raddr = last_idx;
			ST_CHK:  ram_we = store;
			ST_SQ: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(t_cur);
				mul_b  = MUL_W'(t_cur);
			end
			ST_PRD: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(t_q);
				mul_b  = MUL_W'(a_q);
			end
			ST_D1: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(cnt_q);
				mul_b  = stt_q[31:0];
			end
			ST_D2: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(cnt_q);
				mul_b  = stt_q[63:32];
			end
			ST_D3: begin
				mul_en = 1'b1;
				mul_a  = st_q;
				mul_b  = st_q;
			end
			ST_D4: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(cnt_q);
				mul_b  = sta_q[31:0];
			end
			ST_D5: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(cnt_q);
				mul_b  = sta_q[63:32];
			end
			ST_D6: begin
				mul_en = 1'b1;
				mul_a  = st_q;
				mul_b  = MUL_W'(sa_q);
			end
			ST_D9: begin
				mul_en = 1'b1;
				mul_a  = mag_q[31:0];
				mul_b  = SLOPE_SCALE;
			end
			ST_D10: begin
				mul_en = 1'b1;
				mul_a  = mag_q[63:32];
				mul_b  = SLOPE_SCALE;
			end
			ST_D11: div_start = 1'b1;
			ST_T2: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(seg_q.x);
				mul_b  = MUL_W'(seg_q.dm);
			end
			ST_T3: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(mul_p[15:0]);
				mul_b  = REC25;
			end
			ST_T5: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(tab_q);
				mul_b  = MUL_W'(tf_q);
			end
			ST_T6: begin
				mul_en = 1'b1;
				mul_a  = MUL_W'(mul_p[17:0]);
				mul_b  = REC100;
			end
			default: ;
		endcase
	end

	// ---------------- control and datapath registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			last_chg_q  <= 1'b0;
			held_rem_q  <= '0;
			held_rate_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_PREP: begin
					if (!vld_q) begin
						held_rem_q <= '1;
					end else begin
						last_chg_q <= chg_q;
						if (!chg_q && adc_q < ADC_EMPTY) begin
							head_q     <= head0;
							cnt_q      <= cnt0;
							held_rem_q <= '0;
						end else begin
							head_q <= head1;
							cnt_q  <= cnt1;
						end
					end
				end
				ST_CHK: begin
					head_q <= nh;
					cnt_q  <= nc;
					if (nc < CNT_W'(3)) held_rate_q <= '0;
				end
				ST_DEC: begin
					if (chg_q ? s_pos : s_neg) begin
						held_rate_q <= rate6;
					end else begin
						held_rem_q  <= '1;
						held_rate_q <= '0;
					end
				end
				ST_T7: begin
					if (chg_q && adc_q <= ADC_LOW) held_rem_q <= '1;
					else if (chg_q && adc_q >= ADC_FULL) held_rem_q <= '0;
					else held_rem_q <= scaled;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				vld_q <= s_tuser[0];
				chg_q <= s_tuser[1];
				adc_q <= s_tdata[ADC_W-1:0];
				now_q <= s_tdata[ADC_W +: TIME_W];
			end
			ST_PREP: h_q <= h_eff;
			ST_CHK: begin
				idx_q <= oldest;
				i_q   <= '0;
				st_q  <= '0;
				sa_q  <= '0;
				stt_q <= '0;
				sta_q <= '0;
			end
			ST_SQ: begin
				if (i_q == '0) t0_q <= rd_time;
				t_q <= t_cur;
				a_q <= rd_lvl;
			end
			ST_PRD: stt_q <= stt_q + mul_p;
			ST_ACC: begin
				sta_q <= sta_q + mul_p;
				st_q  <= st_q + 32'(t_q);
				sa_q  <= sa_q + 16'(a_q);
				i_q   <= i_q + CNT_W'(1);
				idx_q <= (CNT_W'(idx_q) + CNT_W'(1) == h_q) ? '0
					: IDX_W'(CNT_W'(idx_q) + CNT_W'(1));
			end
			ST_D2:  acc_q <= mul_p;
			ST_D3:  den_q <= acc_q + {mul_p[31:0], 32'b0};
			ST_D4:  den_q <= den_q - mul_p;
			ST_D5:  acc_q <= mul_p;
			ST_D6:  acc_q <= acc_q + {mul_p[31:0], 32'b0};
			ST_D7:  acc_q <= acc_q - mul_p;
			ST_D8: begin
				neg_q <= acc_q[63];
				mag_q <= acc_q[63] ? 64'(-acc_q) : acc_q;
			end
			ST_D10: acc_q <= mul_p;
			ST_T1:  seg_q <= chg_q ? chg_seg(adc_q) : dis_seg(adc_q);
			ST_T4:  tab_q <= seg_q.base + mul_p[REC25_SH +: 8];
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= M_DATA_W'({held_rate_q, held_rem_q});
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ---------------- assertions ----------------
	`ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready,
		"reading taken while the previous one is still in work")
	`ASSERT_IMPLY(a_walk_in_range, state_q == ST_ACC, i_q < cnt_q && cnt_q <= h_q,
		"regression walk beyond the filled history")
	`ASSERT_IMPLY(a_idx_in_ring, state_q == ST_RD, CNT_W'(idx_q) < h_q,
		"history read outside the ring in use")
	`ASSERT_NEXT(a_div_handoff, state_q == ST_DIV && div_stat.done, state_q == ST_DEC,
		"sequencer missed the end of the divide")

endmodule
